### src/lc3ie_pkg.sv
// Package for the LC-3 instruction execute block: constants, command types and helpers.
// No dependencies.
package lc3ie_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_WORDS = 1 << ADDR_BITS;

  localparam logic [2:0] ACT_MEM_WR = 3'd0;
  localparam logic [2:0] ACT_MEM_RD = 3'd1;
  localparam logic [2:0] ACT_REG_WR = 3'd2;
  localparam logic [2:0] ACT_SET_PC = 3'd3;
  localparam logic [2:0] ACT_STEP   = 3'd4;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] TRAP_GETC = 8'h20;
  localparam logic [7:0] TRAP_OUT  = 8'h21;
  localparam logic [7:0] TRAP_HALT = 8'h25;

  localparam logic [2:0] CC_RESET = 3'b010;

  // Memory address source select.
  localparam logic [1:0] MA_HOST = 2'd0;
  localparam logic [1:0] MA_PC   = 2'd1;
  localparam logic [1:0] MA_EA   = 2'd2;
  localparam logic [1:0] MA_MDR  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;     // capture the input item
    logic       clr_wr;      // write zero at the clear counter
    logic [1:0] mem_addr_sel;
    logic       mem_rd;
    logic       mem_wr_host; // write host data at the host address
    logic       mem_wr_ea;   // store register at the effective address
    logic       mem_wr_mdr;  // store register at the loaded pointer
    logic       load_ir;     // capture fetched word
    logic       load_mdr;    // capture read data as pointer
    logic       exec;        // retire the instruction (non-memory or final)
    logic       exec_mem;    // retire with read data as value
    logic       host_apply;  // apply a non-step host action
    logic       load_out;
  } lc3ie_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] opcode;
    logic       halted;
    logic       clr_done;
  } lc3ie_sts_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    else if (v == 16'd0) return 3'b010;
    else return 3'b001;
  endfunction

endpackage

### src/lc3ie_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lc3ie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

### src/lc3ie_ctrl.sv
// Controller state machine for the LC-3 execute block.
// Depends on lc3ie_pkg.
module lc3ie_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  lc3ie_pkg::lc3ie_sts_t  sts,
  output lc3ie_pkg::lc3ie_cmd_t  cmd
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_MEM1  = 4'd5;
  localparam logic [3:0] S_MEM1W = 4'd6;
  localparam logic [3:0] S_MEM2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_HRD   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          lc3ie_pkg::ACT_MEM_WR: begin
            cmd.mem_addr_sel = lc3ie_pkg::MA_HOST;
            cmd.mem_wr_host  = 1'b1;
            state_nxt        = S_DONE;
          end
          lc3ie_pkg::ACT_MEM_RD: begin
            cmd.mem_addr_sel = lc3ie_pkg::MA_HOST;
            cmd.mem_rd       = 1'b1;
            state_nxt        = S_HRD;
          end
          lc3ie_pkg::ACT_STEP: begin
            if (sts.halted) state_nxt = S_DONE;
            else begin
              cmd.mem_addr_sel = lc3ie_pkg::MA_PC;
              cmd.mem_rd       = 1'b1;
              state_nxt        = S_FETCH;
            end
          end
          default: begin
            cmd.host_apply = 1'b1;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_HRD: begin
        cmd.host_apply = 1'b1;
        state_nxt      = S_DONE;
      end
      S_FETCH: begin
        cmd.load_ir = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        case (sts.opcode)
          lc3ie_pkg::OP_LD, lc3ie_pkg::OP_LDR, lc3ie_pkg::OP_LDI,
          lc3ie_pkg::OP_STI: begin
            cmd.mem_addr_sel = lc3ie_pkg::MA_EA;
            cmd.mem_rd       = 1'b1;
            state_nxt        = S_MEM1;
          end
          lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STR: begin
            cmd.mem_addr_sel = lc3ie_pkg::MA_EA;
            cmd.mem_wr_ea    = 1'b1;
            cmd.exec         = 1'b1;
            state_nxt        = S_DONE;
          end
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MEM1: begin
        if (sts.opcode == lc3ie_pkg::OP_LDI || sts.opcode == lc3ie_pkg::OP_STI) begin
          cmd.load_mdr = 1'b1;
          state_nxt    = S_MEM1W;
        end else begin
          cmd.exec_mem = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_MEM1W: begin
        cmd.mem_addr_sel = lc3ie_pkg::MA_MDR;
        if (sts.opcode == lc3ie_pkg::OP_STI) begin
          cmd.mem_wr_mdr = 1'b1;
          cmd.exec       = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_MEM2;
        end
      end
      S_MEM2: begin
        cmd.exec_mem = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = 1'b1;
        ovalid_nxt   = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

### src/lc3ie_dp.sv
// Datapath for the LC-3 execute block: memory, register file, PC, CC and result register.
// Depends on lc3ie_pkg and lc3ie_ram.
module lc3ie_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lc3ie_pkg::lc3ie_cmd_t cmd,
  output lc3ie_pkg::lc3ie_sts_t sts,
  input  logic [2:0]            in_action,
  input  logic [15:0]           in_address,
  input  logic [15:0]           in_data,
  input  logic [2:0]            in_reg_index,
  input  logic [7:0]            in_input_char,
  output logic [15:0]           out_pc,
  output logic [2:0]            out_cond_codes,
  output logic                  out_halted,
  output logic [15:0]           out_read_word,
  output logic                  out_char_valid,
  output logic [7:0]            out_char_out
);
  localparam int AW = lc3ie_pkg::ADDR_BITS;

  logic [2:0]  act_r;
  logic [15:0] addr_r, data_r;
  logic [2:0]  ri_r;
  logic [7:0]  ch_r;
  logic [15:0] ir_r, mdr_r, pc_r;
  logic [15:0] rf_r [8];
  logic [2:0]  cc_r;
  logic        halt_r;
  logic [AW-1:0] clr_r;
  logic        emit_r;
  logic [7:0]  och_r;
  logic [15:0] rd_r;

  logic [15:0] rdata, pc1, off9, off6, off11, op2, sr1v, drv, ea;
  logic [AW-1:0] maddr;
  logic [15:0]   wdata;
  logic          we;
  logic [3:0]    opc;

  assign opc  = ir_r[15:12];
  assign pc1  = pc_r + 16'd1;
  assign off9 = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6 = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11 = {{5{ir_r[10]}}, ir_r[10:0]};
  assign sr1v = rf_r[ir_r[8:6]];
  assign drv  = rf_r[ir_r[11:9]];
  assign op2  = ir_r[5] ? {{11{ir_r[4]}}, ir_r[4:0]} : rf_r[ir_r[2:0]];
  assign ea   = (opc == lc3ie_pkg::OP_LDR || opc == lc3ie_pkg::OP_STR) ?
                sr1v + off6 : pc1 + off9;

  always_comb begin
    case (cmd.mem_addr_sel)
      lc3ie_pkg::MA_HOST: maddr = addr_r[AW-1:0];
      lc3ie_pkg::MA_PC:   maddr = pc_r[AW-1:0];
      lc3ie_pkg::MA_EA:   maddr = ea[AW-1:0];
      default:            maddr = mdr_r[AW-1:0];
    endcase
    if (cmd.clr_wr) maddr = clr_r;
    we    = cmd.clr_wr || cmd.mem_wr_host || cmd.mem_wr_ea || cmd.mem_wr_mdr;
    wdata = cmd.clr_wr ? 16'd0 : (cmd.mem_wr_host ? data_r : drv);
  end

  lc3ie_ram #(.WIDTH(16), .DEPTH(lc3ie_pkg::MEM_WORDS)) u_mem (
    .clk(clk), .we(we), .addr(maddr), .wdata(wdata), .re(cmd.mem_rd), .rdata(rdata)
  );

  assign sts.action   = act_r;
  assign sts.opcode   = opc;
  assign sts.halted   = halt_r;
  assign sts.clr_done = clr_r == {AW{1'b1}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      pc_r   <= '0;
      cc_r   <= lc3ie_pkg::CC_RESET;
      halt_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= '0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (cmd.load_in) begin
        act_r <= in_action; addr_r <= in_address; data_r <= in_data;
        ri_r  <= in_reg_index; ch_r <= in_input_char;
        emit_r <= 1'b0; rd_r <= '0;
      end
      if (cmd.load_ir)  ir_r  <= rdata;
      if (cmd.load_mdr) mdr_r <= rdata;
      if (cmd.host_apply) begin
        case (act_r)
          lc3ie_pkg::ACT_MEM_RD: rd_r <= rdata;
          lc3ie_pkg::ACT_REG_WR: rf_r[ri_r] <= data_r;
          lc3ie_pkg::ACT_SET_PC: pc_r <= data_r;
          default: ;
        endcase
      end
      if (cmd.exec_mem) begin
        rf_r[ir_r[11:9]] <= rdata;
        cc_r <= lc3ie_pkg::cc_of(rdata);
        pc_r <= pc1;
      end
      if (cmd.exec) begin
        pc_r <= pc1;
        case (opc)
          lc3ie_pkg::OP_ADD: begin
            rf_r[ir_r[11:9]] <= sr1v + op2; cc_r <= lc3ie_pkg::cc_of(sr1v + op2);
          end
          lc3ie_pkg::OP_AND: begin
            rf_r[ir_r[11:9]] <= sr1v & op2; cc_r <= lc3ie_pkg::cc_of(sr1v & op2);
          end
          lc3ie_pkg::OP_NOT: begin
            rf_r[ir_r[11:9]] <= ~sr1v; cc_r <= lc3ie_pkg::cc_of(~sr1v);
          end
          lc3ie_pkg::OP_LEA: begin
            rf_r[ir_r[11:9]] <= pc1 + off9; cc_r <= lc3ie_pkg::cc_of(pc1 + off9);
          end
          lc3ie_pkg::OP_BR: if ((ir_r[11:9] & cc_r) != 3'd0) pc_r <= pc1 + off9;
          lc3ie_pkg::OP_JMP: pc_r <= sr1v;
          lc3ie_pkg::OP_JSR: begin
            rf_r[7] <= pc1;
            pc_r <= ir_r[11] ? pc1 + off11 : sr1v;
          end
          lc3ie_pkg::OP_TRAP: begin
            case (ir_r[7:0])
              lc3ie_pkg::TRAP_GETC: rf_r[0] <= {8'd0, ch_r};
              lc3ie_pkg::TRAP_OUT: begin
                emit_r <= 1'b1; och_r <= rf_r[0][7:0];
              end
              lc3ie_pkg::TRAP_HALT: halt_r <= 1'b1;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pc         <= pc_r;
      out_cond_codes <= cc_r;
      out_halted     <= halt_r;
      out_read_word  <= rd_r;
      out_char_valid <= emit_r;
      out_char_out   <= emit_r ? och_r : 8'd0;
    end
  end
endmodule

### src/lc3_instruction_execute.sv
// LC-3 instruction execute block, top level: controller plus datapath.
// A memory read uses one read of the single memory port; a step uses the fetch read and
// one data read for LD, LDR and STI (which then also writes) or two for LDI; writes, set
// pc, unknown actions and a step while halted use no read.
// One item at a time: the next is taken only after the result is loaded, once the
// result register is free. Reset is synchronous, active low; after it a clearing pass
// zeroes the memory.
// Depends on lc3ie_pkg, lc3ie_ctrl, lc3ie_dp and lc3ie_ram.
module lc3_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_input_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pc,
  output logic [2:0]  out_cond_codes,
  output logic        out_halted,
  output logic [15:0] out_read_word,
  output logic        out_char_valid,
  output logic [7:0]  out_char_out
);
  lc3ie_pkg::lc3ie_cmd_t cmd;
  lc3ie_pkg::lc3ie_sts_t sts;

  // The controller sequences fetch, decode and memory phases.
  lc3ie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  // The datapath holds all architectural state and the result register.
  lc3ie_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_address(in_address), .in_data(in_data),
    .in_reg_index(in_reg_index), .in_input_char(in_input_char),
    .out_pc(out_pc), .out_cond_codes(out_cond_codes), .out_halted(out_halted),
    .out_read_word(out_read_word), .out_char_valid(out_char_valid),
    .out_char_out(out_char_out)
  );
endmodule
